/* rtl/mocs_pkg.sv */
package mocs_pkg;

  localparam int ADDR_BITS = 16;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;
  localparam int WORD_W    = 16;
  localparam int CHAR_W    = 8;

  // instruction word layout
  localparam int IND1_BIT  = 8;
  localparam int IND0_BIT  = 9;
  localparam int WB_BIT    = 10;
  localparam int ARGC_LSB  = 12;
  localparam int KIND_W    = 8;

  localparam logic [KIND_W-1:0] K_COPY = 8'd1;
  localparam logic [KIND_W-1:0] K_ADD  = 8'd3;
  localparam logic [KIND_W-1:0] K_JZ   = 8'd4;
  localparam logic [KIND_W-1:0] K_POKE = 8'd5;
  localparam logic [KIND_W-1:0] K_HALT = 8'd6;

  // item opcodes
  localparam logic [1:0] OP_MEM_WR = 2'd0;
  localparam logic [1:0] OP_MEM_RD = 2'd1;
  localparam logic [1:0] OP_SET_PC = 2'd2;
  localparam logic [1:0] OP_EXEC   = 2'd3;

  typedef enum logic [2:0] {
    AS_NONE, AS_PC, AS_ITEM, AS_WADDR, AS_OP0, AS_OP1, AS_CLR
  } addr_sel_t;

  typedef enum logic [1:0] {
    WD_ZERO, WD_ITEM, WD_RES
  } wd_sel_t;

  typedef enum logic [2:0] {
    D_NONE, D_INS, D_WADDR, D_OP0, D_OP1, D_RD
  } dst_t;

  typedef enum logic [3:0] {
    C_NEVER, C_HALTED, C_NO_WB, C_ARGC_LT1, C_ARGC_LT2, C_ARGC_LT3,
    C_NO_IND0, C_NO_IND1, C_CLR_MORE
  } cond_t;

  // the clearing step sits at the top code so that falling through wraps to idle
  typedef enum logic [4:0] {
    ST_IDLE    = 5'd0,
    ST_MW      = 5'd1,
    ST_MR      = 5'd2,
    ST_MR_WAIT = 5'd3,
    ST_SETPC   = 5'd4,
    ST_FETCH   = 5'd5,
    ST_WADDR   = 5'd6,
    ST_ARG0    = 5'd7,
    ST_ARG1    = 5'd8,
    ST_ARG2    = 5'd9,
    ST_IND0    = 5'd10,
    ST_IND1    = 5'd11,
    ST_OPWAIT  = 5'd12,
    ST_EXEC    = 5'd13,
    ST_WBACK   = 5'd14,
    ST_NOP     = 5'd15,
    ST_CLR     = 5'd31
  } step_t;

  typedef struct packed {
    addr_sel_t addr_sel;
    logic      mem_rd;
    logic      mem_wr;
    wd_sel_t   wd_sel;
    dst_t      dst;
    logic      pc_inc;
    logic      pc_set;
    logic      exec;
    logic      clr_inc;
    cond_t     skip_cond;
    cond_t     br_cond;
    step_t     br_target;
    logic      dispatch;
    logic      done;
  } ucw_t;

  typedef struct packed {
    addr_sel_t addr_sel;
    logic      mem_rd;
    logic      mem_wr;
    wd_sel_t   wd_sel;
    dst_t      dst;
    logic      pc_inc;
    logic      pc_set;
    logic      exec;
    logic      clr_inc;
    logic      adv;
    logic      done;
    logic      ready;
  } ctl_t;

  typedef struct packed {
    logic       halted;
    logic       wb;
    logic       ind0;
    logic       ind1;
    logic [1:0] argc;
    logic       clr_more;
    logic       out_stall;
  } stat_t;

  function automatic ucw_t ucode(input step_t s);
    ucw_t w;
    w = '0;
    case (s)
      ST_IDLE: begin
        w.dispatch = 1'b1;
      end
      ST_CLR: begin
        w.addr_sel  = AS_CLR;
        w.mem_wr    = 1'b1;
        w.wd_sel    = WD_ZERO;
        w.clr_inc   = 1'b1;
        w.br_cond   = C_CLR_MORE;
        w.br_target = ST_CLR;
      end
      ST_MW: begin
        w.addr_sel = AS_ITEM;
        w.mem_wr   = 1'b1;
        w.wd_sel   = WD_ITEM;
        w.done     = 1'b1;
      end
      ST_MR: begin
        w.addr_sel = AS_ITEM;
        w.mem_rd   = 1'b1;
        w.dst      = D_RD;
      end
      ST_MR_WAIT: begin
        w.done = 1'b1;
      end
      ST_SETPC: begin
        w.pc_set = 1'b1;
        w.done   = 1'b1;
      end
      ST_FETCH: begin
        w.addr_sel  = AS_PC;
        w.mem_rd    = 1'b1;
        w.dst       = D_INS;
        w.pc_inc    = 1'b1;
        w.skip_cond = C_HALTED;
        w.br_cond   = C_HALTED;
        w.br_target = ST_NOP;
      end
      ST_WADDR: begin
        w.addr_sel  = AS_PC;
        w.mem_rd    = 1'b1;
        w.dst       = D_WADDR;
        w.pc_inc    = 1'b1;
        w.skip_cond = C_NO_WB;
      end
      ST_ARG0: begin
        w.addr_sel  = AS_PC;
        w.mem_rd    = 1'b1;
        w.dst       = D_OP0;
        w.pc_inc    = 1'b1;
        w.skip_cond = C_ARGC_LT1;
      end
      ST_ARG1: begin
        w.addr_sel  = AS_PC;
        w.mem_rd    = 1'b1;
        w.dst       = D_OP1;
        w.pc_inc    = 1'b1;
        w.skip_cond = C_ARGC_LT2;
      end
      ST_ARG2: begin
        // third operand is never used by any operation: just step over it
        w.pc_inc    = 1'b1;
        w.skip_cond = C_ARGC_LT3;
      end
      ST_IND0: begin
        w.addr_sel  = AS_OP0;
        w.mem_rd    = 1'b1;
        w.dst       = D_OP0;
        w.skip_cond = C_NO_IND0;
      end
      ST_IND1: begin
        w.addr_sel  = AS_OP1;
        w.mem_rd    = 1'b1;
        w.dst       = D_OP1;
        w.skip_cond = C_NO_IND1;
      end
      ST_OPWAIT: begin
        w.dispatch = 1'b0;
      end
      ST_EXEC: begin
        w.exec = 1'b1;
      end
      ST_WBACK: begin
        w.addr_sel  = AS_WADDR;
        w.mem_wr    = 1'b1;
        w.wd_sel    = WD_RES;
        w.skip_cond = C_NO_WB;
        w.done      = 1'b1;
      end
      ST_NOP: begin
        w.done = 1'b1;
      end
      default: begin
        w.dispatch = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/mocs_in_if.sv */
interface mocs_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic [mocs_pkg::WORD_W-1:0]  address;
  logic [mocs_pkg::WORD_W-1:0]  data;

  modport source (output valid, output opcode, output address, output data, input ready);
  modport sink   (input valid, input opcode, input address, input data, output ready);
endinterface

/* rtl/mocs_out_if.sv */
interface mocs_out_if;
  logic                         valid;
  logic                         ready;
  logic [mocs_pkg::WORD_W-1:0]  pc_value;
  logic                         is_halted;
  logic                         char_valid;
  logic [mocs_pkg::CHAR_W-1:0]  char_out;
  logic [mocs_pkg::WORD_W-1:0]  read_data;
  logic [mocs_pkg::WORD_W-1:0]  result_value;

  modport source (output valid, output pc_value, output is_halted, output char_valid,
                  output char_out, output read_data, output result_value, input ready);
  modport sink   (input valid, input pc_value, input is_halted, input char_valid,
                  input char_out, input read_data, input result_value, output ready);
endinterface

/* rtl/memory_operand_cpu_step_top.sv */
// Items are taken one at a time: in_ch.ready is high only in idle, and each item runs
// its microprogram back to idle; on a halted machine execute skips to a no-op step.
// Cycle count follows the microprogram: every instruction word, operand and
// indirection goes through the single memory port one access per step.
// Reset (rst_n low, synchronous) clears step, pc, halt, operands and result; then a
// clearing pass writes zero to all 2^ADDR_BITS memory words with in_ch.ready low.
module memory_operand_cpu_step_top (
  input  logic       clk,
  input  logic       rst_n,
  mocs_in_if.sink    in_ch,
  mocs_out_if.source out_ch
);

  mocs_pkg::ctl_t  ctl;
  mocs_pkg::stat_t stat;
  logic            in_fire;

  assign in_ch.ready = ctl.ready;
  assign in_fire     = in_ch.valid && ctl.ready;

  mocs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_opcode (in_ch.opcode),
    .stat      (stat),
    .ctl       (ctl)
  );

  mocs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .in_fire          (in_fire),
    .in_address       (in_ch.address),
    .in_data          (in_ch.data),
    .out_ready        (out_ch.ready),
    .stat             (stat),
    .out_valid        (out_ch.valid),
    .out_pc_value     (out_ch.pc_value),
    .out_is_halted    (out_ch.is_halted),
    .out_char_valid   (out_ch.char_valid),
    .out_char_out     (out_ch.char_out),
    .out_read_data    (out_ch.read_data),
    .out_result_value (out_ch.result_value)
  );

endmodule

/* rtl/mocs_ram.sv */
module mocs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/mocs_seq.sv */
module mocs_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic [1:0]      in_opcode,
  input  mocs_pkg::stat_t stat,
  output mocs_pkg::ctl_t  ctl
);

  mocs_pkg::step_t step_r, step_nxt;
  mocs_pkg::ucw_t  w;
  logic            skip, br, adv, act;

  function automatic logic cond_eval(input mocs_pkg::cond_t c, input mocs_pkg::stat_t s);
    logic r;
    r = 1'b0;
    case (c)
      mocs_pkg::C_NEVER:    r = 1'b0;
      mocs_pkg::C_HALTED:   r = s.halted;
      mocs_pkg::C_NO_WB:    r = !s.wb;
      mocs_pkg::C_ARGC_LT1: r = (s.argc < 2'd1);
      mocs_pkg::C_ARGC_LT2: r = (s.argc < 2'd2);
      mocs_pkg::C_ARGC_LT3: r = (s.argc < 2'd3);
      mocs_pkg::C_NO_IND0:  r = !s.ind0;
      mocs_pkg::C_NO_IND1:  r = !s.ind1;
      mocs_pkg::C_CLR_MORE: r = s.clr_more;
      default:              r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic mocs_pkg::step_t entry(input logic [1:0] op);
    mocs_pkg::step_t e;
    e = mocs_pkg::ST_IDLE;
    case (op)
      mocs_pkg::OP_MEM_WR: e = mocs_pkg::ST_MW;
      mocs_pkg::OP_MEM_RD: e = mocs_pkg::ST_MR;
      mocs_pkg::OP_SET_PC: e = mocs_pkg::ST_SETPC;
      mocs_pkg::OP_EXEC:   e = mocs_pkg::ST_FETCH;
      default:             e = mocs_pkg::ST_IDLE;
    endcase
    return e;
  endfunction

  always_comb begin
    w    = mocs_pkg::ucode(step_r);
    skip = cond_eval(w.skip_cond, stat);
    br   = cond_eval(w.br_cond, stat);
    // hold the final step while the previous result is still waiting
    adv  = !(w.done && stat.out_stall);
    act  = adv && !skip;
  end

  always_comb begin
    ctl.addr_sel = w.addr_sel;
    ctl.mem_rd   = w.mem_rd && act;
    ctl.mem_wr   = w.mem_wr && act;
    ctl.wd_sel   = w.wd_sel;
    ctl.dst      = w.dst;
    ctl.pc_inc   = w.pc_inc && act;
    ctl.pc_set   = w.pc_set && act;
    ctl.exec     = w.exec && act;
    ctl.clr_inc  = w.clr_inc && act;
    ctl.adv      = adv;
    ctl.done     = w.done && adv;
    ctl.ready    = (step_r == mocs_pkg::ST_IDLE);
  end

  always_comb begin
    step_nxt = step_r;
    if (w.dispatch) begin
      if (in_fire) begin
        step_nxt = entry(in_opcode);
      end
    end else if (!adv) begin
      step_nxt = step_r;
    end else if (br) begin
      step_nxt = w.br_target;
    end else if (w.done) begin
      step_nxt = mocs_pkg::ST_IDLE;
    end else begin
      step_nxt = mocs_pkg::step_t'(step_r + 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= mocs_pkg::ST_CLR;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* rtl/mocs_dp.sv */
module mocs_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mocs_pkg::ctl_t               ctl,
  input  logic                         in_fire,
  input  logic [mocs_pkg::WORD_W-1:0]  in_address,
  input  logic [mocs_pkg::WORD_W-1:0]  in_data,
  input  logic                         out_ready,
  output mocs_pkg::stat_t              stat,
  output logic                         out_valid,
  output logic [mocs_pkg::WORD_W-1:0]  out_pc_value,
  output logic                         out_is_halted,
  output logic                         out_char_valid,
  output logic [mocs_pkg::CHAR_W-1:0]  out_char_out,
  output logic [mocs_pkg::WORD_W-1:0]  out_read_data,
  output logic [mocs_pkg::WORD_W-1:0]  out_result_value
);

  localparam int AW = mocs_pkg::ADDR_BITS;
  localparam int DW = mocs_pkg::WORD_W;
  localparam int CW = mocs_pkg::CHAR_W;

  logic [DW-1:0]  item_addr_r, item_data_r;
  logic [DW-1:0]  pc_r, pc_nxt;
  logic           halt_r, halt_nxt;
  logic [DW-1:0]  ins_r, ins_nxt, ins_cur;
  logic [DW-1:0]  waddr_r, waddr_nxt;
  logic [DW-1:0]  op0_r, op0_nxt;
  logic [DW-1:0]  op1_r, op1_nxt;
  logic [DW-1:0]  res_r, res_nxt;
  logic           cv_r, cv_nxt;
  logic [CW-1:0]  ch_r, ch_nxt;
  logic [DW-1:0]  rd_r, rd_nxt;
  mocs_pkg::dst_t pend_r, pend_nxt;
  logic [AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [DW-1:0]  out_pc_r, out_rd_r, out_res_r;
  logic           out_halt_r, out_cv_r;
  logic [CW-1:0]  out_ch_r;

  logic [AW-1:0]  mem_addr;
  logic [DW-1:0]  mem_wdata, mem_rdata;
  logic [mocs_pkg::KIND_W-1:0] kind;

  mocs_ram #(.WIDTH(DW), .DEPTH(mocs_pkg::MEM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ctl.mem_wr),
    .re    (ctl.mem_rd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    case (ctl.addr_sel)
      mocs_pkg::AS_PC:    mem_addr = pc_r[AW-1:0];
      mocs_pkg::AS_ITEM:  mem_addr = item_addr_r[AW-1:0];
      mocs_pkg::AS_WADDR: mem_addr = waddr_r[AW-1:0];
      mocs_pkg::AS_OP0:   mem_addr = op0_r[AW-1:0];
      mocs_pkg::AS_OP1:   mem_addr = op1_r[AW-1:0];
      mocs_pkg::AS_CLR:   mem_addr = clr_addr_r;
      default:            mem_addr = '0;
    endcase
    case (ctl.wd_sel)
      mocs_pkg::WD_ITEM: mem_wdata = item_data_r;
      mocs_pkg::WD_RES:  mem_wdata = res_r;
      default:           mem_wdata = '0;
    endcase
  end

  // the instruction word may still be in the read register
  assign ins_cur = (pend_r == mocs_pkg::D_INS) ? mem_rdata : ins_r;
  assign kind    = ins_r[mocs_pkg::KIND_W-1:0];

  always_comb begin
    stat.halted    = halt_r;
    stat.wb        = ins_cur[mocs_pkg::WB_BIT];
    stat.ind0      = ins_cur[mocs_pkg::IND0_BIT];
    stat.ind1      = ins_cur[mocs_pkg::IND1_BIT];
    stat.argc      = ins_cur[mocs_pkg::ARGC_LSB +: 2];
    stat.clr_more  = !(&clr_addr_r);
    stat.out_stall = out_valid_r && !out_ready;
  end

  always_comb begin
    pc_nxt       = pc_r;
    halt_nxt     = halt_r;
    ins_nxt      = ins_r;
    waddr_nxt    = waddr_r;
    op0_nxt      = op0_r;
    op1_nxt      = op1_r;
    res_nxt      = res_r;
    cv_nxt       = cv_r;
    ch_nxt       = ch_r;
    rd_nxt       = rd_r;
    clr_addr_nxt = clr_addr_r;

    if (in_fire) begin
      cv_nxt = 1'b0;
      ch_nxt = '0;
      rd_nxt = '0;
    end

    // land the word read in the previous step
    if (ctl.adv) begin
      case (pend_r)
        mocs_pkg::D_INS:   ins_nxt   = mem_rdata;
        mocs_pkg::D_WADDR: waddr_nxt = mem_rdata;
        mocs_pkg::D_OP0:   op0_nxt   = mem_rdata;
        mocs_pkg::D_OP1:   op1_nxt   = mem_rdata;
        mocs_pkg::D_RD:    rd_nxt    = mem_rdata;
        default: ;
      endcase
    end

    if (ctl.pc_inc) begin
      pc_nxt = pc_r + 16'd1;
    end
    if (ctl.pc_set) begin
      pc_nxt   = item_addr_r;
      halt_nxt = 1'b0;
    end
    if (ctl.clr_inc) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
    end

    if (ctl.exec) begin
      case (kind)
        mocs_pkg::K_COPY: res_nxt = op0_r;
        mocs_pkg::K_ADD:  res_nxt = op0_r + op1_r;
        mocs_pkg::K_JZ: begin
          if (op1_r == '0) begin
            pc_nxt = op0_r;
          end
        end
        mocs_pkg::K_POKE: begin
          cv_nxt = 1'b1;
          ch_nxt = op1_r[CW-1:0];
        end
        mocs_pkg::K_HALT: halt_nxt = 1'b1;
        default: ;
      endcase
    end

    if (ctl.mem_rd) begin
      pend_nxt = ctl.dst;
    end else if (ctl.adv) begin
      pend_nxt = mocs_pkg::D_NONE;
    end else begin
      pend_nxt = pend_r;
    end

    if (ctl.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      halt_r      <= 1'b0;
      op0_r       <= '0;
      op1_r       <= '0;
      res_r       <= '0;
      pend_r      <= mocs_pkg::D_NONE;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      halt_r      <= halt_nxt;
      op0_r       <= op0_nxt;
      op1_r       <= op1_nxt;
      res_r       <= res_nxt;
      pend_r      <= pend_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_addr_r <= in_address;
      item_data_r <= in_data;
    end
    ins_r   <= ins_nxt;
    waddr_r <= waddr_nxt;
    cv_r    <= cv_nxt;
    ch_r    <= ch_nxt;
    rd_r    <= rd_nxt;
    if (ctl.done) begin
      out_pc_r   <= pc_nxt;
      out_halt_r <= halt_nxt;
      out_cv_r   <= cv_nxt;
      out_ch_r   <= ch_nxt;
      out_rd_r   <= rd_nxt;
      out_res_r  <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pc_value     = out_pc_r;
  assign out_is_halted    = out_halt_r;
  assign out_char_valid   = out_cv_r;
  assign out_char_out     = out_ch_r;
  assign out_read_data    = out_rd_r;
  assign out_result_value = out_res_r;

endmodule

/* rtl/mocs_chk.sv */
module mocs_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_is_halted,
  input logic                         out_char_valid,
  input logic [mocs_pkg::CHAR_W-1:0]  out_char_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new item taken while one is in progress");

  a_poke_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_valid |-> !out_is_halted)
    else $error("poke reported on a halted machine");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_valid |-> out_char_out == '0)
    else $error("character byte set without a poke");

endmodule

bind memory_operand_cpu_step_top mocs_chk u_mocs_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_is_halted  (out_ch.is_halted),
  .out_char_valid (out_ch.char_valid),
  .out_char_out   (out_ch.char_out)
);
